[src/isotp_pkg.sv]
// ----------------------------------------------------------------------------
// ISO-TP reassembler package
// Shared types and constants for the frame classifier, queue and session unit.
// ----------------------------------------------------------------------------
`default_nettype none

package isotp_pkg;

	localparam int unsigned ISOTP_QUEUE_DEPTH = 2;

	localparam logic [3:0] PCI_SINGLE   = 4'h0;
	localparam logic [3:0] PCI_FIRST    = 4'h1;
	localparam logic [3:0] PCI_CONSEC   = 4'h2;
	localparam logic [3:0] NIBBLE_MASK  = 4'hF;
	localparam logic [3:0] FRAME_MAX    = 4'd8;
	localparam logic [3:0] FRAME_MIN    = 4'd2;
	localparam logic [3:0] SF_MAX_LEN   = 4'd7;
	localparam logic [3:0] FF_MAX_SEG   = 4'd6;
	localparam logic [3:0] FIRST_SEQ    = 4'd1;

	typedef enum logic [1:0] {
		KIND_REJECT,
		KIND_SINGLE,
		KIND_FIRST,
		KIND_CONSEC
	} frame_kind_t;

	typedef enum logic {
		SESS_IDLE,
		SESS_RECV
	} sess_state_t;

	typedef struct packed {
		frame_kind_t      kind;
		logic [3:0]       seq;
		logic [2:0]       count;
		logic [11:0]      total;
		logic             ff_done;
		logic [6:0][7:0]  data;
	} cls_item_t;

endpackage

`default_nettype wire

[src/isotp_front.sv]
// ----------------------------------------------------------------------------
// ISO-TP frame classifier
// Decodes the PCI byte, checks frame lengths and aligns the payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module isotp_front
	import isotp_pkg::*;
(
	input  wire logic [3:0] frame_len,
	input  wire logic [7:0] frame_b0,
	input  wire logic [7:0] frame_b1,
	input  wire logic [7:0] frame_b2,
	input  wire logic [7:0] frame_b3,
	input  wire logic [7:0] frame_b4,
	input  wire logic [7:0] frame_b5,
	input  wire logic [7:0] frame_b6,
	input  wire logic [7:0] frame_b7,
	output cls_item_t       item
);

	logic [3:0]  len8;
	logic [3:0]  ftype;
	logic [3:0]  low;
	logic [11:0] total;
	logic [3:0]  ff_seg;
	logic [3:0]  ff_clip;
	logic        sf_ok;

	assign len8    = (frame_len > FRAME_MAX) ? FRAME_MAX : frame_len;
	assign ftype   = frame_b0[7:4] & NIBBLE_MASK;
	assign low     = frame_b0[3:0] & NIBBLE_MASK;
	assign total   = {low, frame_b1};
	assign ff_seg  = (len8 >= FRAME_MAX) ? FF_MAX_SEG : len8 - FRAME_MIN;
	assign ff_clip = ({8'h00, ff_seg} > total) ? total[3:0] : ff_seg;
	assign sf_ok   = (low >= 4'd1) && (low <= SF_MAX_LEN) && ((len8 - 4'd1) >= low);

	always_comb begin
		item.kind    = KIND_REJECT;
		item.seq     = low;
		item.count   = 3'd0;
		item.total   = total;
		item.ff_done = ({8'h00, ff_seg} >= total);
		item.data    = {frame_b7, frame_b6, frame_b5, frame_b4, frame_b3, frame_b2, frame_b1};
		if (len8 >= FRAME_MIN) begin
			priority if (ftype == PCI_SINGLE) begin
				if (sf_ok) begin
					item.kind  = KIND_SINGLE;
					item.count = low[2:0];
				end
			end else if (ftype == PCI_FIRST) begin
				if (total != 12'd0) begin
					item.kind  = KIND_FIRST;
					item.count = ff_clip[2:0];
					item.data  = {8'h00, frame_b7, frame_b6, frame_b5, frame_b4, frame_b3,
						frame_b2};
				end
			end else if (ftype == PCI_CONSEC) begin
				item.kind  = KIND_CONSEC;
				item.count = 3'(len8 - 4'd1);
			end
		end
	end

endmodule

`default_nettype wire

[src/isotp_queue.sv]
// ----------------------------------------------------------------------------
// ISO-TP item queue
// Short FIFO of classified frames between the classifier and the session unit.
// ----------------------------------------------------------------------------
`default_nettype none

module isotp_queue
	import isotp_pkg::*;
#(
	parameter int unsigned DEPTH = ISOTP_QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire cls_item_t push_item,
	input  wire logic      pop,
	output logic           full,
	output logic           not_empty,
	output cls_item_t      head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cls_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		ptr_next = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[src/isotp_back.sv]
// ----------------------------------------------------------------------------
// ISO-TP session unit
// Tracks the reassembly session, clips segments and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module isotp_back
	import isotp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire cls_item_t   item,
	output logic             pop,
	input  wire logic        seg_stall,
	output logic             seg_valid,
	output logic             accepted,
	output logic             msg_start,
	output logic             msg_done,
	output logic             msg_abort,
	output logic [2:0]       seg_count,
	output logic [6:0][7:0]  seg_data
);

	sess_state_t  state_q, state_d;
	logic [11:0]  declared_q, declared_d;
	logic [11:0]  received_q, received_d;
	logic [3:0]   exp_seq_q, exp_seq_d;

	logic         out_valid_q;
	logic         acc_q, start_q, done_q, abort_q;
	logic [2:0]   count_q;
	logic [6:0][7:0] data_q;

	logic         acc_c, start_c, done_c, abort_c;
	logic [2:0]   count_c;
	logic [6:0][7:0] data_c;

	logic         receiving;
	logic         seq_ok;
	logic [11:0]  remaining;
	logic [2:0]   cf_count;
	logic [11:0]  cf_received;
	logic         cf_reach;

	assign receiving   = (state_q == SESS_RECV);
	assign seq_ok      = (item.seq == (exp_seq_q & NIBBLE_MASK));
	assign remaining   = (declared_q > received_q) ? declared_q - received_q : 12'd0;
	assign cf_count    = ({9'd0, item.count} > remaining) ? remaining[2:0] : item.count;
	assign cf_received = received_q + {9'd0, cf_count};
	assign cf_reach    = (cf_received >= declared_q);

	assign pop = item_valid && (!out_valid_q || !seg_stall);

	always_comb begin
		state_d    = state_q;
		declared_d = declared_q;
		received_d = received_q;
		exp_seq_d  = exp_seq_q;
		unique case (item.kind)
			KIND_SINGLE: begin
				state_d    = SESS_IDLE;
				declared_d = 12'd0;
				received_d = 12'd0;
				exp_seq_d  = FIRST_SEQ;
			end
			KIND_FIRST: begin
				state_d    = item.ff_done ? SESS_IDLE : SESS_RECV;
				declared_d = item.ff_done ? 12'd0 : item.total;
				received_d = item.ff_done ? 12'd0 : {9'd0, item.count};
				exp_seq_d  = FIRST_SEQ;
			end
			KIND_CONSEC: begin
				if (receiving) begin
					if (!seq_ok || cf_reach) begin
						state_d    = SESS_IDLE;
						declared_d = 12'd0;
						received_d = 12'd0;
						exp_seq_d  = FIRST_SEQ;
					end else begin
						received_d = cf_received;
						exp_seq_d  = (exp_seq_q + 4'd1) & NIBBLE_MASK;
					end
				end
			end
			default: begin
				state_d = state_q;
			end
		endcase
	end

	always_comb begin
		acc_c   = 1'b0;
		start_c = 1'b0;
		done_c  = 1'b0;
		abort_c = 1'b0;
		count_c = 3'd0;
		unique case (item.kind)
			KIND_SINGLE: begin
				acc_c   = 1'b1;
				start_c = 1'b1;
				done_c  = 1'b1;
				abort_c = receiving;
				count_c = item.count;
			end
			KIND_FIRST: begin
				acc_c   = 1'b1;
				start_c = 1'b1;
				done_c  = item.ff_done;
				abort_c = receiving;
				count_c = item.count;
			end
			KIND_CONSEC: begin
				if (receiving) begin
					if (!seq_ok) begin
						abort_c = 1'b1;
					end else begin
						acc_c   = 1'b1;
						done_c  = cf_reach;
						count_c = cf_count;
					end
				end
			end
			default: begin
				acc_c = 1'b0;
			end
		endcase
		for (int i = 0; i < 7; i++) begin
			data_c[i] = (3'(i) < count_c) ? item.data[i] : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SESS_IDLE;
			declared_q  <= 12'd0;
			received_q  <= 12'd0;
			exp_seq_q   <= FIRST_SEQ;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				state_q     <= state_d;
				declared_q  <= declared_d;
				received_q  <= received_d;
				exp_seq_q   <= exp_seq_d;
				out_valid_q <= 1'b1;
			end else if (!seg_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q   <= acc_c;
			start_q <= start_c;
			done_q  <= done_c;
			abort_q <= abort_c;
			count_q <= count_c;
			data_q  <= data_c;
		end
	end

	assign seg_valid = out_valid_q;
	assign accepted  = acc_q;
	assign msg_start = start_q;
	assign msg_done  = done_q;
	assign msg_abort = abort_q;
	assign seg_count = count_q;
	assign seg_data  = data_q;

endmodule

`default_nettype wire

[src/isotp_frame_reassembler.sv]
// ----------------------------------------------------------------------------
// ISO-TP frame reassembler
// Classifies CAN frames and emits one payload segment with flags per frame.
// ----------------------------------------------------------------------------
// channel   handshake                 payload
// frame     frame_valid / frame_stall frame_len, frame_b0 .. frame_b7
// segment   seg_valid / seg_stall     accepted, msg_*, seg_count, seg_b0 .. seg_b6
//
// One frame per cycle sustained while seg_stall is low; a frame passes the queue
// and then the output register before its segment is on the segment port (the
// queue takes it at the accepting edge, the output loads when the session pops it).
// Reset returns the session to idle and empties the queue.
// frame_stall rises only while the queue is full; seg_stall holds the output.
// ----------------------------------------------------------------------------
`default_nettype none

module isotp_frame_reassembler
	import isotp_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = ISOTP_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       frame_valid,
	output logic            frame_stall,
	input  wire logic [3:0] frame_len,
	input  wire logic [7:0] frame_b0,
	input  wire logic [7:0] frame_b1,
	input  wire logic [7:0] frame_b2,
	input  wire logic [7:0] frame_b3,
	input  wire logic [7:0] frame_b4,
	input  wire logic [7:0] frame_b5,
	input  wire logic [7:0] frame_b6,
	input  wire logic [7:0] frame_b7,
	output logic            seg_valid,
	input  wire logic       seg_stall,
	output logic            accepted,
	output logic            msg_start,
	output logic            msg_done,
	output logic            msg_abort,
	output logic [2:0]      seg_count,
	output logic [7:0]      seg_b0,
	output logic [7:0]      seg_b1,
	output logic [7:0]      seg_b2,
	output logic [7:0]      seg_b3,
	output logic [7:0]      seg_b4,
	output logic [7:0]      seg_b5,
	output logic [7:0]      seg_b6
);

	cls_item_t        cls_item;
	cls_item_t        head_item;
	logic             q_full;
	logic             q_not_empty;
	logic             q_pop;
	logic             q_push;
	logic [6:0][7:0]  seg_data;

	assign frame_stall = q_full;
	assign q_push      = frame_valid && !q_full;

	isotp_front u_front (
		.frame_len (frame_len),
		.frame_b0  (frame_b0),
		.frame_b1  (frame_b1),
		.frame_b2  (frame_b2),
		.frame_b3  (frame_b3),
		.frame_b4  (frame_b4),
		.frame_b5  (frame_b5),
		.frame_b6  (frame_b6),
		.frame_b7  (frame_b7),
		.item      (cls_item)
	);

	isotp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (cls_item),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head_item)
	);

	isotp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_not_empty),
		.item       (head_item),
		.pop        (q_pop),
		.seg_stall  (seg_stall),
		.seg_valid  (seg_valid),
		.accepted   (accepted),
		.msg_start  (msg_start),
		.msg_done   (msg_done),
		.msg_abort  (msg_abort),
		.seg_count  (seg_count),
		.seg_data   (seg_data)
	);

	assign seg_b0 = seg_data[0];
	assign seg_b1 = seg_data[1];
	assign seg_b2 = seg_data[2];
	assign seg_b3 = seg_data[3];
	assign seg_b4 = seg_data[4];
	assign seg_b5 = seg_data[5];
	assign seg_b6 = seg_data[6];

	a_done_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && (msg_done || msg_start) |-> accepted)
		else $error("start or done on a rejected frame");

	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !accepted |-> seg_count == 3'd0 && seg_b0 == 8'h00)
		else $error("rejected frame carries payload");

	a_cf_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && accepted && !msg_start |-> seg_count != 3'd0)
		else $error("consecutive segment without bytes");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("queue popped while empty");

endmodule

`default_nettype wire
